// ===== rtl/pcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsm_pkg
// Shared types and constants of the pixel color select mask unit: hue
// scale, divider shape, register indexes and the stage records of the
// hue pipeline.
// ----------------------------------------------------------------------------
package pcsm_pkg;

    // color channel width and hue word width (0 .. 1530 * 256)
    localparam int unsigned CH_W       = 8;
    localparam int unsigned HUE_W      = 19;
    localparam int unsigned RANGE_W    = 18;
    localparam int unsigned CENTER_W   = 24;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 2;

    // hue scale in q8
    localparam logic [HUE_W-1:0] HUE_HALF_Q8 = HUE_W'(765 * 256);
    localparam logic [HUE_W-1:0] HUE_FULL_Q8 = HUE_W'(1530 * 256);

    // divider: 16 quotient bits, 4 per pipeline stage
    localparam int unsigned QUO_W         = 16;
    localparam int unsigned DIV_STEP_BITS = 4;
    localparam int unsigned DIV_STAGES    = QUO_W / DIV_STEP_BITS;

    // channel index of the sector's leading component
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd3;

    // distance mode
    localparam logic MODE_HUE = 1'b0;
    localparam logic MODE_BOX = 1'b1;

    // sector analysis result
    typedef struct packed {
        logic            grey;
        logic [2:0]      sector;
        logic [CH_W-1:0] mid;
        logic [CH_W-1:0] span;
    } hue_front_t;

    // divider working record: partial remainder, numerator bits shifting out
    // at the top while quotient bits shift in at the bottom
    typedef struct packed {
        logic             grey;
        logic             zero_span;
        logic [2:0]       sector;
        logic [CH_W-1:0]  span;
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] nq;
    } hue_work_t;

endpackage

// ===== rtl/pcsm_div_stage.sv =====
// ----------------------------------------------------------------------------
// pcsm_div_stage
// One registered stage of the restoring divider: four quotient bits of
// numerator / span per clock while en is high.
// ----------------------------------------------------------------------------
module pcsm_div_stage (
    input  logic                  aclk,
    input  logic                  en,
    input  pcsm_pkg::hue_work_t   work_in,
    output pcsm_pkg::hue_work_t   work_out
);

    pcsm_pkg::hue_work_t work_next;
    pcsm_pkg::hue_work_t work_reg;

    // restoring steps, one quotient bit each
    always_comb begin
        logic [pcsm_pkg::CH_W:0] trial;
        logic                    ge;
        work_next = work_in;
        for (int i = 0; i < int'(pcsm_pkg::DIV_STEP_BITS); i++) begin
            trial = {work_next.rem, work_next.nq[pcsm_pkg::QUO_W-1]};
            ge    = (trial >= {1'b0, work_next.span});
            if (ge) begin
                work_next.rem = pcsm_pkg::CH_W'(trial - {1'b0, work_next.span});
            end else begin
                work_next.rem = trial[pcsm_pkg::CH_W-1:0];
            end
            work_next.nq = {work_next.nq[pcsm_pkg::QUO_W-2:0], ge};
        end
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
        end
    end

    assign work_out = work_reg;

endmodule

// ===== rtl/pcsm_hue_pipe.sv =====
// ----------------------------------------------------------------------------
// pcsm_hue_pipe
// Hexcone hue of one color in q8, fraction truncated. Seven register
// stages: sector analysis, numerator, four divider stages, hue assembly.
// ----------------------------------------------------------------------------
module pcsm_hue_pipe (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [pcsm_pkg::CH_W-1:0]       red,
    input  logic [pcsm_pkg::CH_W-1:0]       green,
    input  logic [pcsm_pkg::CH_W-1:0]       blue,
    output logic [pcsm_pkg::HUE_W-1:0]      hue
);

    logic [1:0]                  top;
    logic [pcsm_pkg::CH_W-1:0]   c_top;
    logic [pcsm_pkg::CH_W-1:0]   c_mid;
    logic [pcsm_pkg::CH_W-1:0]   c_lo;
    logic                        sec1;
    pcsm_pkg::hue_front_t        front_next;
    pcsm_pkg::hue_front_t        front_reg;
    logic [23:0]                 num;
    pcsm_pkg::hue_work_t         work_next;
    pcsm_pkg::hue_work_t         work_reg;
    pcsm_pkg::hue_work_t         div_chain [pcsm_pkg::DIV_STAGES+1];
    pcsm_pkg::hue_work_t         div_last;
    logic [pcsm_pkg::HUE_W-1:0]  base;
    logic [pcsm_pkg::HUE_W-1:0]  hue_next;
    logic [pcsm_pkg::HUE_W-1:0]  hue_reg;

    // sector analysis: leading channel, offset within sector and span
    always_comb begin
        if (blue < red) begin
            top = (green < blue) ? pcsm_pkg::CH_BLUE : pcsm_pkg::CH_RED;
        end else begin
            top = (red < green) ? pcsm_pkg::CH_GREEN : pcsm_pkg::CH_BLUE;
        end
        unique case (top)
            pcsm_pkg::CH_RED: begin
                c_top = red;   c_mid = green; c_lo = blue;
            end
            pcsm_pkg::CH_GREEN: begin
                c_top = green; c_mid = blue;  c_lo = red;
            end
            default: begin
                c_top = blue;  c_mid = red;   c_lo = green;
            end
        endcase
        sec1              = (c_mid > c_top);
        front_next.grey   = (red == green) && (red == blue);
        front_next.sector = {top, sec1};
        front_next.mid    = sec1 ? (c_mid - c_top) : (c_mid - c_lo);
        front_next.span   = sec1 ? (c_mid - c_lo) : (c_top - c_lo);
    end

    // numerator mid * 255 * 256, upper byte seeds the remainder
    always_comb begin
        num = {front_reg.mid, 16'd0} - {8'd0, front_reg.mid, 8'd0};
        work_next.grey      = front_reg.grey;
        work_next.zero_span = (front_reg.span == '0);
        work_next.sector    = front_reg.sector;
        work_next.span      = front_reg.span;
        work_next.rem       = num[23:16];
        work_next.nq        = num[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
            work_reg  <= work_next;
        end
    end

    // divider stages
    assign div_chain[0] = work_reg;

    for (genvar s = 0; s < int'(pcsm_pkg::DIV_STAGES); s++) begin : g_div
        pcsm_div_stage u_div_stage (
            .aclk     (aclk),
            .en       (en),
            .work_in  (div_chain[s]),
            .work_out (div_chain[s+1])
        );
    end

    assign div_last = div_chain[pcsm_pkg::DIV_STAGES];

    // hue = sector * 255 * 256 + fraction; grey is 0
    always_comb begin
        base = {div_last.sector, 16'd0} - {8'd0, div_last.sector, 8'd0};
        if (div_last.grey) begin
            hue_next = '0;
        end else if (div_last.zero_span) begin
            hue_next = base;
        end else begin
            hue_next = base + {3'd0, div_last.nq};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg <= hue_next;
        end
    end

    assign hue = hue_reg;

endmodule

// ===== rtl/pixel_color_select_mask_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_color_select_mask_unit
// Color key mask: one select bit per rgb pixel, by hue distance or by
// per-channel box distance to a configured center color.
// ----------------------------------------------------------------------------
// The unit takes one pixel item per clock while the result side does not
// stall, and returns its select bit at the end of a pipeline made of the
// hue path: sector analysis, numerator, a four-stage radix-16 restoring
// divider, hue assembly, hue difference and the final wrap and compare.
// A stall on the result side holds the whole pipeline in place; s_ready
// follows !m_valid || m_ready. The center hue runs through its own copy of
// the hue pipeline in lockstep with the pixels, so registers may be written
// at any idle time and take effect from the next accepted item.
module pixel_color_select_mask_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [pcsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // pixel items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pcsm_pkg::CH_W-1:0]           s_red,
    input  logic [pcsm_pkg::CH_W-1:0]           s_green,
    input  logic [pcsm_pkg::CH_W-1:0]           s_blue,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_selected
);

    localparam int unsigned HUE_LAT = 3 + pcsm_pkg::DIV_STAGES;
    localparam int unsigned MID_LAT = HUE_LAT + 1;

    logic                             mode_reg;
    logic [pcsm_pkg::CENTER_W-1:0]    center_reg;
    logic [pcsm_pkg::RANGE_W-1:0]     range_reg;
    logic                             invert_reg;

    logic                             en;
    logic [MID_LAT-1:0]               vld_reg;
    logic [MID_LAT-1:0]               box_hit_reg;
    logic                             box_hit_next;
    logic [pcsm_pkg::HUE_W-1:0]       hue_pix;
    logic [pcsm_pkg::HUE_W-1:0]       hue_ctr;
    logic [pcsm_pkg::HUE_W-1:0]       dist_next;
    logic [pcsm_pkg::HUE_W-1:0]       dist_reg;
    logic [pcsm_pkg::HUE_W-1:0]       range_ext;
    logic                             hue_hit;
    logic                             m_valid_reg;
    logic                             m_selected_reg;
    logic                             m_selected_next;
    logic [pcsm_pkg::CH_W-1:0]        ctr_red;
    logic [pcsm_pkg::CH_W-1:0]        ctr_green;
    logic [pcsm_pkg::CH_W-1:0]        ctr_blue;
    logic [pcsm_pkg::CH_W-1:0]        diff_r;
    logic [pcsm_pkg::CH_W-1:0]        diff_g;
    logic [pcsm_pkg::CH_W-1:0]        diff_b;
    logic [pcsm_pkg::RANGE_W-9:0]     box_lim;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= pcsm_pkg::MODE_HUE;
            center_reg <= '0;
            range_reg  <= '0;
            invert_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcsm_pkg::CFG_MODE:   mode_reg   <= cfg_wdata[0];
                pcsm_pkg::CFG_CENTER: center_reg <= cfg_wdata[pcsm_pkg::CENTER_W-1:0];
                pcsm_pkg::CFG_RANGE:  range_reg  <= cfg_wdata[pcsm_pkg::RANGE_W-1:0];
                pcsm_pkg::CFG_INVERT: invert_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign ctr_red   = center_reg[23:16];
    assign ctr_green = center_reg[15:8];
    assign ctr_blue  = center_reg[7:0];

    // pipeline advance
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // hue of pixel and center
    pcsm_hue_pipe u_hue_pix (
        .aclk  (aclk),
        .en    (en),
        .red   (s_red),
        .green (s_green),
        .blue  (s_blue),
        .hue   (hue_pix)
    );

    pcsm_hue_pipe u_hue_ctr (
        .aclk  (aclk),
        .en    (en),
        .red   (ctr_red),
        .green (ctr_green),
        .blue  (ctr_blue),
        .hue   (hue_ctr)
    );

    // box distance on the raw pixel
    always_comb begin
        diff_r  = (s_red   > ctr_red)   ? s_red   - ctr_red   : ctr_red   - s_red;
        diff_g  = (s_green > ctr_green) ? s_green - ctr_green : ctr_green - s_green;
        diff_b  = (s_blue  > ctr_blue)  ? s_blue  - ctr_blue  : ctr_blue  - s_blue;
        box_lim = range_reg[pcsm_pkg::RANGE_W-1:8];
        box_hit_next = ({2'd0, diff_r} <= box_lim) && ({2'd0, diff_g} <= box_lim)
                    && ({2'd0, diff_b} <= box_lim);
    end

    // hue difference
    assign dist_next = (hue_pix >= hue_ctr) ? (hue_pix - hue_ctr) : (hue_ctr - hue_pix);

    // valid bits and box result travel alongside the hue pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[MID_LAT-2:0], s_valid};
            m_valid_reg <= vld_reg[MID_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            box_hit_reg    <= {box_hit_reg[MID_LAT-2:0], box_hit_next};
            dist_reg       <= dist_next;
            m_selected_reg <= m_selected_next;
        end
    end

    // wrap at half circle, compare, pick mode, invert
    always_comb begin
        range_ext = {1'b0, range_reg};
        if (dist_reg > pcsm_pkg::HUE_HALF_Q8) begin
            hue_hit = (pcsm_pkg::HUE_FULL_Q8 - dist_reg) <= range_ext;
        end else begin
            hue_hit = dist_reg <= range_ext;
        end
        m_selected_next = ((mode_reg == pcsm_pkg::MODE_BOX) ? box_hit_reg[MID_LAT-1]
                                                             : hue_hit) ^ invert_reg;
    end

    assign m_valid    = m_valid_reg;
    assign m_selected = m_selected_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel color select mask unit: predicts the
// select bit of every accepted pixel in hue and box modes and compares it
// with each result item in order, under random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned HUE_SECTOR_Q8 = 255 * 256;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [pcsm_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [pcsm_pkg::CFG_DATA_W-1:0]     cfg_wdata;
    logic                                s_valid;
    logic                                s_ready;
    logic [pcsm_pkg::CH_W-1:0]           s_red;
    logic [pcsm_pkg::CH_W-1:0]           s_green;
    logic [pcsm_pkg::CH_W-1:0]           s_blue;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic                                m_selected;

    // key settings as the unit should hold them
    logic                                key_mode;
    logic [pcsm_pkg::CENTER_W-1:0]       key_center;
    logic [pcsm_pkg::RANGE_W-1:0]        key_range;
    logic                                key_invert;

    // select bits still owed by the unit, oldest first
    logic select_q[$];
    logic want_bit;

    int unsigned fail_cnt    = 0;
    int unsigned pixel_cnt   = 0;
    int unsigned checked_cnt = 0;
    int unsigned set_cnt     = 0;
    int unsigned setting_cnt = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned stall_left  = 0;
    bit          free_flow   = 1'b0;

    always #5 aclk = ~aclk;

    pixel_color_select_mask_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_red      (s_red),
        .s_green    (s_green),
        .s_blue     (s_blue),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_selected (m_selected)
    );

    // hexcone hue in q8, six sectors of 255, grey gives 0
    function automatic logic [pcsm_pkg::HUE_W-1:0] hue_q8_of(
        logic [pcsm_pkg::CH_W-1:0] r, logic [pcsm_pkg::CH_W-1:0] g,
        logic [pcsm_pkg::CH_W-1:0] b);
        int unsigned ch [3];
        int unsigned lead, nxt, prv, sector, offset, span;
        ch[0] = r;
        ch[1] = g;
        ch[2] = b;
        if (r == g && r == b) return '0;
        // channel that opens the sector
        if (b < r) begin
            lead = (g < b) ? 2 : 0;
        end else begin
            lead = (r < g) ? 1 : 2;
        end
        nxt = (lead + 1) % 3;
        prv = (lead + 2) % 3;
        if (ch[nxt] > ch[lead]) begin
            // second half: next channel has overtaken the leading one
            sector = lead * 2 + 1;
            offset = ch[nxt] - ch[lead];
            span   = ch[nxt] - ch[prv];
        end else begin
            sector = lead * 2;
            offset = ch[nxt] - ch[prv];
            span   = ch[lead] - ch[prv];
        end
        if (span == 0) return pcsm_pkg::HUE_W'(sector * HUE_SECTOR_Q8);
        return pcsm_pkg::HUE_W'(sector * HUE_SECTOR_Q8 + (offset * HUE_SECTOR_Q8) / span);
    endfunction

    function automatic int unsigned chan_gap(logic [pcsm_pkg::CH_W-1:0] a,
                                             logic [pcsm_pkg::CH_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // expected select bit under the current key settings
    function automatic logic predict_select(logic [pcsm_pkg::CH_W-1:0] r,
                                            logic [pcsm_pkg::CH_W-1:0] g,
                                            logic [pcsm_pkg::CH_W-1:0] b);
        int unsigned hp, hc, hue_gap, lim;
        logic hit;
        if (key_mode == pcsm_pkg::MODE_HUE) begin
            hp = hue_q8_of(r, g, b);
            hc = hue_q8_of(key_center[23:16], key_center[15:8], key_center[7:0]);
            hue_gap = (hp > hc) ? hp - hc : hc - hp;
            // take the short way round the hue circle
            if (hue_gap > pcsm_pkg::HUE_HALF_Q8) begin
                hue_gap = (hue_gap <= pcsm_pkg::HUE_FULL_Q8) ?
                          pcsm_pkg::HUE_FULL_Q8 - hue_gap : 0;
            end
            hit = (hue_gap <= key_range);
        end else begin
            lim = key_range >> 8;
            hit = chan_gap(r, key_center[23:16]) <= lim &&
                  chan_gap(g, key_center[15:8]) <= lim &&
                  chan_gap(b, key_center[7:0]) <= lim;
        end
        return hit ^ key_invert;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_pause();
        int unsigned roll;
        if (free_flow) return 0;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    function automatic logic [pcsm_pkg::CH_W-1:0] near_chan(logic [pcsm_pkg::CH_W-1:0] c,
                                                            int spread);
        int v;
        v = int'(c) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pcsm_pkg::CH_W'(v);
    endfunction

    // pixel mix: near the center, anywhere, grey, and channel extremes
    function automatic logic [23:0] pick_pixel(logic [23:0] ctr);
        int unsigned roll, spread;
        logic [pcsm_pkg::CH_W-1:0] v;
        logic [23:0] px;
        roll = $urandom_range(9);
        spread = (roll == 9) ? 2 : $urandom_range(24, 1);
        v = pcsm_pkg::CH_W'($urandom_range(255));
        if (roll <= 3 || roll == 9) begin
            px = {near_chan(ctr[23:16], spread), near_chan(ctr[15:8], spread),
                  near_chan(ctr[7:0], spread)};
        end else if (roll <= 6) begin
            px = 24'($urandom_range(24'hFFFFFF));
        end else if (roll == 7) begin
            px = {v, v, v};
        end else begin
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(2))
                    0: px[i*8 +: 8] = 8'h00;
                    1: px[i*8 +: 8] = 8'hFF;
                    default: px[i*8 +: 8] = 8'($urandom_range(255));
                endcase
            end
        end
        return px;
    endfunction

    function automatic logic [23:0] pick_center();
        logic [pcsm_pkg::CH_W-1:0] v;
        v = pcsm_pkg::CH_W'($urandom_range(255));
        case ($urandom_range(7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return {v, v, v};
            default: return 24'($urandom_range(24'hFFFFFF));
        endcase
    endfunction

    // result side: random stalls unless free flow is on
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= ($urandom_range(2) == 0) ? pick_pause() : 0;
        end
    end

    // compare each result item with the oldest predicted select bit
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (select_q.size() == 0) begin
                $display("%0t: select bit %0b arrived with no pixel outstanding",
                         $time, m_selected);
                fail_cnt++;
            end else begin
                want_bit = select_q.pop_front();
                checked_cnt++;
                if (m_selected) set_cnt++;
                if (m_selected !== want_bit) begin
                    $display("%0t: selected mismatch: expected %0b, actual %0b",
                             $time, want_bit, m_selected);
                    fail_cnt++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("%0t: run limit reached, %0d select bits outstanding",
                     $time, select_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one pixel item, after a random gap
    task automatic send_pixel(logic [23:0] rgb);
        int unsigned gap;
        gap = pick_pause();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= rgb[23:16];
        s_green <= rgb[15:8];
        s_blue  <= rgb[7:0];
        do @(posedge aclk); while (!s_ready);
        select_q.push_back(predict_select(rgb[23:16], rgb[15:8], rgb[7:0]));
        pixel_cnt++;
    endtask

    // hold the sender until every outstanding select bit is back
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (select_q.size() != 0);
    endtask

    task automatic write_reg(logic [pcsm_pkg::CFG_IDX_W-1:0] idx,
                             logic [pcsm_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // new key settings, written while the unit is idle
    task automatic set_key(logic mode, logic [pcsm_pkg::CENTER_W-1:0] ctr,
                           logic [pcsm_pkg::RANGE_W-1:0] rng, logic inv);
        wait_results();
        write_reg(pcsm_pkg::CFG_MODE, pcsm_pkg::CFG_DATA_W'(mode));
        write_reg(pcsm_pkg::CFG_CENTER, pcsm_pkg::CFG_DATA_W'(ctr));
        write_reg(pcsm_pkg::CFG_RANGE, pcsm_pkg::CFG_DATA_W'(rng));
        write_reg(pcsm_pkg::CFG_INVERT, pcsm_pkg::CFG_DATA_W'(inv));
        cfg_wr_en <= 1'b0;
        key_mode   = mode;
        key_center = ctr;
        key_range  = rng;
        key_invert = inv;
        setting_cnt++;
    endtask

    // settings straight out of reset: hue mode, black center, zero range
    task automatic test_reset_values();
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h00FF00);
    endtask

    // primaries, secondaries, greys, wrap past the red end, half-circle tie
    task automatic test_hue_directed();
        logic [23:0] pix [12] = '{24'hFF0000, 24'hFF1400, 24'hFF0019, 24'hFF0028,
                                 24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
                                 24'hFF00FF, 24'h808080, 24'h010000, 24'h7F0080};
        set_key(pcsm_pkg::MODE_HUE, 24'hFF0000, 18'(30 * 256), 1'b0);
        foreach (pix[i]) send_pixel(pix[i]);
        // range beyond the half circle with inversion: all clear
        set_key(pcsm_pkg::MODE_HUE, 24'h0000FF, 18'h3FFFF, 1'b1);
        send_pixel(24'hFFFF00);
        send_pixel(24'h808080);
        // range exactly half the circle
        set_key(pcsm_pkg::MODE_HUE, 24'h00FFFF,
                pcsm_pkg::HUE_HALF_Q8[pcsm_pkg::RANGE_W-1:0], 1'b0);
        send_pixel(24'hFF0000);
    endtask

    // box edges, fraction ignored, zero and largest range
    task automatic test_box_directed();
        set_key(pcsm_pkg::MODE_BOX, 24'h6496C8, {10'd10, 8'hFF}, 1'b0);
        send_pixel(24'h6E8CBE);
        send_pixel(24'h6F96C8);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        set_key(pcsm_pkg::MODE_BOX, 24'h6496C8, '0, 1'b1);
        send_pixel(24'h6496C8);
        send_pixel(24'h6496C9);
        set_key(pcsm_pkg::MODE_BOX, 24'h00FF00, 18'h3FFFF, 1'b0);
        send_pixel(24'hFF00FF);
    endtask

    task automatic test_hue_random();
        logic [pcsm_pkg::RANGE_W-1:0] rng;
        for (int k = 0; k < 10; k++) begin
            case (k)
                0: rng = '0;
                1: rng = pcsm_pkg::HUE_HALF_Q8[pcsm_pkg::RANGE_W-1:0];
                2: rng = 18'h3FFFF;
                3: rng = pcsm_pkg::HUE_HALF_Q8[pcsm_pkg::RANGE_W-1:0] - 1;
                default: rng = 18'($urandom_range(90 * 256));
            endcase
            set_key(pcsm_pkg::MODE_HUE, pick_center(), rng, 1'($urandom_range(1)));
            free_flow = ($urandom_range(3) == 0);
            for (int n = 0; n < 40; n++) send_pixel(pick_pixel(key_center));
        end
        free_flow = 1'b0;
    endtask

    task automatic test_box_random();
        logic [pcsm_pkg::RANGE_W-1:0] rng;
        for (int k = 0; k < 10; k++) begin
            case (k)
                0: rng = '0;
                1: rng = 18'h3FFFF;
                2: rng = 18'h000FF;
                default: rng = {10'($urandom_range(40)), 8'($urandom_range(255))};
            endcase
            set_key(pcsm_pkg::MODE_BOX, pick_center(), rng, 1'($urandom_range(1)));
            free_flow = ($urandom_range(3) == 0);
            for (int n = 0; n < 40; n++) send_pixel(pick_pixel(key_center));
        end
        free_flow = 1'b0;
    endtask

    // bursts with the sender holding mid-burst until all results are back
    task automatic test_pause_for_results();
        logic [pcsm_pkg::RANGE_W-1:0] rng;
        for (int k = 0; k < 6; k++) begin
            rng = (k[0] == pcsm_pkg::MODE_HUE) ? 18'($urandom_range(60 * 256))
                                     : {10'($urandom_range(30)), 8'($urandom_range(255))};
            set_key(k[0], pick_center(), rng, 1'($urandom_range(1)));
            for (int n = 0; n < 25; n++) begin
                if (n == 12) wait_results();
                send_pixel(pick_pixel(key_center));
            end
        end
    endtask

    // one pixel per clock with the result side always ready
    task automatic test_back_to_back();
        set_key(pcsm_pkg::MODE_HUE, pick_center(), 18'($urandom_range(40 * 256)), 1'b0);
        free_flow = 1'b1;
        for (int n = 0; n < 65; n++) send_pixel(pick_pixel(key_center));
        set_key(pcsm_pkg::MODE_BOX, pick_center(), {10'($urandom_range(20)), 8'h80}, 1'b1);
        for (int n = 0; n < 60; n++) send_pixel(pick_pixel(key_center));
        free_flow = 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= pcsm_pkg::CFG_MODE;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_red     <= '0;
        s_green   <= '0;
        s_blue    <= '0;
        key_mode   = pcsm_pkg::MODE_HUE;
        key_center = '0;
        key_range  = '0;
        key_invert = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_hue_directed();
        test_box_directed();
        test_hue_random();
        test_box_random();
        test_pause_for_results();
        test_back_to_back();

        wait_results();
        repeat (20) @(posedge aclk);
        $display("pixels sent %0d over %0d key settings (hue and box, invert, range edges)",
                 pixel_cnt, setting_cnt);
        $display("select bits checked %0d, %0d of them set, %0d mismatches",
                 checked_cnt, set_cnt, fail_cnt);
        if (fail_cnt == 0 && select_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcsm_pkg.sv
rtl/pcsm_div_stage.sv
rtl/pcsm_hue_pipe.sv
rtl/pixel_color_select_mask_unit.sv
dv/tb.sv
